### rtl/dsg_pkg.sv
// ----------------------------------------------------------------------------
// dsg_pkg
// Shared types, register codes and the sine table of the DDS sine generator.
// ----------------------------------------------------------------------------
package dsg_pkg;

  // Fixed widths of the payload and the table
  localparam int unsigned WORD_BITS     = 16;
  localparam int unsigned SAMPLE_BITS   = 12;
  localparam int unsigned ROM_ADDR_BITS = 8;
  localparam int unsigned ROM_DEPTH     = 256;
  localparam int unsigned CFG_IDX_BITS  = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_TUNE_STEP  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_UPPER_LIMIT = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_LOWER_LIMIT = 2'd2;

  // Reset values
  localparam logic [WORD_BITS-1:0] TUNE_STEP_RST   = 16'd256;
  localparam logic [WORD_BITS-1:0] UPPER_LIMIT_RST = 16'd16000;
  localparam logic [WORD_BITS-1:0] LOWER_LIMIT_RST = 16'd260;
  localparam logic [WORD_BITS-1:0] TUNING_WORD_RST = 16'd1024;

  typedef struct packed {
    logic tick;
    logic up_button_n;
    logic down_button_n;
  } in_item_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample;
    logic [WORD_BITS-1:0]   phase_step_used;
  } out_item_t;

  // Register write transaction toward the tuner
  typedef struct packed {
    logic                    wr;
    logic [CFG_IDX_BITS-1:0] idx;
    logic [WORD_BITS-1:0]    data;
  } cfg_wr_t;

  // One period of offset-binary sine, 12 bits
  localparam logic [SAMPLE_BITS-1:0] SINE_TABLE [ROM_DEPTH] = '{
    12'h800,12'h832,12'h864,12'h896,12'h8c8,12'h8fa,12'h92c,12'h95e,
    12'h98f,12'h9c0,12'h9f1,12'ha22,12'ha52,12'ha82,12'hab1,12'hae0,
    12'hb0f,12'hb3d,12'hb6b,12'hb98,12'hbc5,12'hbf1,12'hc1c,12'hc47,
    12'hc71,12'hc9a,12'hcc3,12'hceb,12'hd12,12'hd39,12'hd5f,12'hd83,
    12'hda7,12'hdca,12'hded,12'he0e,12'he2e,12'he4e,12'he6c,12'he8a,
    12'hea6,12'hec1,12'hedc,12'hef5,12'hf0d,12'hf24,12'hf3a,12'hf4f,
    12'hf63,12'hf76,12'hf87,12'hf98,12'hfa7,12'hfb5,12'hfc2,12'hfcd,
    12'hfd8,12'hfe1,12'hfe9,12'hff0,12'hff5,12'hff9,12'hffd,12'hffe,
    12'hfff,12'hffe,12'hffd,12'hff9,12'hff5,12'hff0,12'hfe9,12'hfe1,
    12'hfd8,12'hfcd,12'hfc2,12'hfb5,12'hfa7,12'hf98,12'hf87,12'hf76,
    12'hf63,12'hf4f,12'hf3a,12'hf24,12'hf0d,12'hef5,12'hedc,12'hec1,
    12'hea6,12'he8a,12'he6c,12'he4e,12'he2e,12'he0e,12'hded,12'hdca,
    12'hda7,12'hd83,12'hd5f,12'hd39,12'hd12,12'hceb,12'hcc3,12'hc9a,
    12'hc71,12'hc47,12'hc1c,12'hbf1,12'hbc5,12'hb98,12'hb6b,12'hb3d,
    12'hb0f,12'hae0,12'hab1,12'ha82,12'ha52,12'ha22,12'h9f1,12'h9c0,
    12'h98f,12'h95e,12'h92c,12'h8fa,12'h8c8,12'h896,12'h864,12'h832,
    12'h800,12'h7cd,12'h79b,12'h769,12'h737,12'h705,12'h6d3,12'h6a1,
    12'h670,12'h63f,12'h60e,12'h5dd,12'h5ad,12'h57d,12'h54e,12'h51f,
    12'h4f0,12'h4c2,12'h494,12'h467,12'h43a,12'h40e,12'h3e3,12'h3b8,
    12'h38e,12'h365,12'h33c,12'h314,12'h2ed,12'h2c6,12'h2a0,12'h27c,
    12'h258,12'h235,12'h212,12'h1f1,12'h1d1,12'h1b1,12'h193,12'h175,
    12'h159,12'h13e,12'h123,12'h10a,12'h0f2,12'h0db,12'h0c5,12'h0b0,
    12'h09c,12'h089,12'h078,12'h067,12'h058,12'h04a,12'h03d,12'h032,
    12'h027,12'h01e,12'h016,12'h00f,12'h00a,12'h006,12'h002,12'h001,
    12'h000,12'h001,12'h002,12'h006,12'h00a,12'h00f,12'h016,12'h01e,
    12'h027,12'h032,12'h03d,12'h04a,12'h058,12'h067,12'h078,12'h089,
    12'h09c,12'h0b0,12'h0c5,12'h0db,12'h0f2,12'h10a,12'h123,12'h13e,
    12'h159,12'h175,12'h193,12'h1b1,12'h1d1,12'h1f1,12'h212,12'h235,
    12'h258,12'h27c,12'h2a0,12'h2c6,12'h2ed,12'h314,12'h33c,12'h365,
    12'h38e,12'h3b8,12'h3e3,12'h40e,12'h43a,12'h467,12'h494,12'h4c2,
    12'h4f0,12'h51f,12'h54e,12'h57d,12'h5ad,12'h5dd,12'h60e,12'h63f,
    12'h670,12'h6a1,12'h6d3,12'h705,12'h737,12'h769,12'h79b,12'h7cd
  };

endpackage

### rtl/dsg_sine_rom.sv
// ----------------------------------------------------------------------------
// dsg_sine_rom
// Synchronous 256 x 12 sine ROM with registered read data and read enable.
// ----------------------------------------------------------------------------
module dsg_sine_rom (
  input  logic                                clk,
  input  logic                                rd_en,
  input  logic [dsg_pkg::ROM_ADDR_BITS-1:0]   rd_addr,
  output logic [dsg_pkg::SAMPLE_BITS-1:0]     rd_data
);

  logic [dsg_pkg::SAMPLE_BITS-1:0] rom_q_r;

  // Read on enable, hold otherwise
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rom_q_r <= dsg_pkg::SINE_TABLE[rd_addr];
    end
  end

  assign rd_data = rom_q_r;

endmodule

### rtl/dsg_tuner.sv
// ----------------------------------------------------------------------------
// dsg_tuner
// Phase accumulator, button edge latches, tuning word and tuning registers.
// Produces the ROM address of the new phase and the tuning word used.
// ----------------------------------------------------------------------------
module dsg_tuner #(
  parameter int unsigned PHASE_BITS = 16,
  parameter int unsigned INDEX_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  dsg_pkg::cfg_wr_t                    cfg_wr,
  input  logic                                accept,
  input  dsg_pkg::in_item_t                   item,
  output logic [dsg_pkg::ROM_ADDR_BITS-1:0]   rom_addr,
  output logic [dsg_pkg::WORD_BITS-1:0]       tw_used
);

  localparam int unsigned WB = dsg_pkg::WORD_BITS;
  localparam int unsigned AB = dsg_pkg::ROM_ADDR_BITS;

  logic [WB-1:0]         step_r, upper_r, lower_r;
  logic [WB-1:0]         tw_r, tw_nxt, tw_up;
  logic                  up_lat_r, down_lat_r;
  logic [PHASE_BITS-1:0] phase_r, phase_nxt, tw_ext;
  logic [INDEX_BITS-1:0] idx;
  logic                  up_pr, down_pr;

  // Configuration register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= dsg_pkg::TUNE_STEP_RST;
      upper_r <= dsg_pkg::UPPER_LIMIT_RST;
      lower_r <= dsg_pkg::LOWER_LIMIT_RST;
    end else if (cfg_wr.wr) begin
      unique case (cfg_wr.idx)
        dsg_pkg::REG_TUNE_STEP:   step_r  <= cfg_wr.data;
        dsg_pkg::REG_UPPER_LIMIT: upper_r <= cfg_wr.data;
        dsg_pkg::REG_LOWER_LIMIT: lower_r <= cfg_wr.data;
        default: ;
      endcase
    end
  end

  // Fit the tuning word to the accumulator width
  generate
    if (PHASE_BITS > WB) begin : g_tw_wide
      assign tw_ext = {{(PHASE_BITS-WB){1'b0}}, tw_r};
    end else begin : g_tw_narrow
      assign tw_ext = tw_r[PHASE_BITS-1:0];
    end
  endgenerate

  assign phase_nxt = phase_r + tw_ext;

  // Top bits of the new phase, then rescaled to the ROM address
  generate
    if (INDEX_BITS > PHASE_BITS) begin : g_idx_pad
      assign idx = {phase_nxt, {(INDEX_BITS-PHASE_BITS){1'b0}}};
    end else begin : g_idx_cut
      assign idx = phase_nxt[PHASE_BITS-1 -: INDEX_BITS];
    end
    if (INDEX_BITS > AB) begin : g_addr_cut
      assign rom_addr = idx[INDEX_BITS-1 -: AB];
    end else if (INDEX_BITS < AB) begin : g_addr_pad
      assign rom_addr = {idx, {(AB-INDEX_BITS){1'b0}}};
    end else begin : g_addr_eq
      assign rom_addr = idx;
    end
  endgenerate

  // New presses: up first, down sees the result of up
  always_comb begin
    up_pr   = !item.up_button_n && !up_lat_r;
    down_pr = !item.down_button_n && !down_lat_r;
    tw_up   = (up_pr && (tw_r < upper_r)) ? tw_r + step_r : tw_r;
    tw_nxt  = (down_pr && (tw_up > lower_r)) ? tw_up - step_r : tw_up;
  end

  // Advance buttons and tuning word on every accepted transaction, phase on ticks
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= '0;
      tw_r       <= dsg_pkg::TUNING_WORD_RST;
      up_lat_r   <= 1'b0;
      down_lat_r <= 1'b0;
    end else if (accept) begin
      if (item.tick) begin
        phase_r <= phase_nxt;
      end
      tw_r       <= tw_nxt;
      up_lat_r   <= !item.up_button_n;
      down_lat_r <= !item.down_button_n;
    end
  end

  assign tw_used = tw_r;

endmodule

### rtl/dds_sine_generator_with_tuning.sv
// ----------------------------------------------------------------------------
// dds_sine_generator_with_tuning
// DDS sine generator: phase accumulator into a sine ROM, tuning word
// stepped up and down by edge-detected buttons.
//
//   channel  direction  handshake          payload
//   in_      input      in_valid/in_stall  dsg_pkg::in_item_t
//   out_     output     out_valid/out_stall dsg_pkg::out_item_t
//   cfg_     input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// One transaction per cycle sustained while out_stall is low. The ROM read
// register loads at the accepting edge and the output register loads from
// it on out_move, so out_valid rises once an accepted tick reaches it.
// Polls without a tick update the buttons and produce no result.
// Synchronous reset restores registers, phase and tuning word; no clear pass.
// Output stall holds the output register, then the ROM stage, then in_stall.
// ----------------------------------------------------------------------------
module dds_sine_generator_with_tuning #(
  parameter int unsigned PHASE_BITS = 16,
  parameter int unsigned INDEX_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  dsg_pkg::in_item_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output dsg_pkg::out_item_t                  out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [dsg_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [dsg_pkg::WORD_BITS-1:0]       cfg_data
);

  logic                                 in_acc;
  logic                                 s1_vld_r, s1_adv, out_move;
  logic                                 out_vld_r;
  dsg_pkg::out_item_t                   out_data_r;
  logic [dsg_pkg::WORD_BITS-1:0]        s1_tw_r, tw_used;
  logic [dsg_pkg::ROM_ADDR_BITS-1:0]    rom_addr;
  logic [dsg_pkg::SAMPLE_BITS-1:0]      rom_data;
  dsg_pkg::cfg_wr_t                     cfg_wr;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = '{wr: cfg_valid, idx: cfg_index, data: cfg_data};

  // Pipeline flow control
  assign out_move = s1_vld_r && (!out_vld_r || !out_stall);
  assign s1_adv   = !s1_vld_r || out_move;
  assign in_stall = !s1_adv;
  assign in_acc   = in_valid && s1_adv;

  dsg_tuner #(
    .PHASE_BITS (PHASE_BITS),
    .INDEX_BITS (INDEX_BITS)
  ) u_tuner (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_wr   (cfg_wr),
    .accept   (in_acc),
    .item     (in_data),
    .rom_addr (rom_addr),
    .tw_used  (tw_used)
  );

  dsg_sine_rom u_rom (
    .clk     (clk),
    .rd_en   (s1_adv),
    .rd_addr (rom_addr),
    .rd_data (rom_data)
  );

  // ROM stage: mark ticks, hold the tuning word beside the read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (s1_adv) begin
      s1_vld_r <= in_acc && in_data.tick;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s1_tw_r <= tw_used;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_move) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_move) begin
      out_data_r <= '{sample: rom_data, phase_step_used: s1_tw_r};
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_tick_enters_rom: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.tick |=> s1_vld_r)
    else $error("accepted tick did not reach ROM stage");

  a_stall_means_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_vld_r && out_vld_r)
    else $error("input stalled with room in the pipeline");

  a_rom_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r && !out_move |=> s1_vld_r && $stable(s1_tw_r) && $stable(rom_data))
    else $error("ROM stage lost a held sample");

  a_move_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_move |=> out_vld_r && (out_data.phase_step_used == $past(s1_tw_r)))
    else $error("output register missed a sample");
`endif

endmodule
